// ===== sv/pqb_pkg.sv =====
// types and codes shared by the paced two-queue priority buffer
package pqb_pkg;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PASS   = 3'd1,
    ACT_QHIGH  = 3'd2,
    ACT_QLOW   = 3'd3,
    ACT_DROP   = 3'd4,
    ACT_IGNORE = 3'd5,
    ACT_SENT   = 3'd6
  } action_e;

  localparam logic [1:0] REQ_ARRIVAL = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;
  localparam logic [1:0] REQ_STOP    = 2'd3;

  localparam logic [1:0] CFG_QUEUE_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_PACE_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_PEER_ADDRESS  = 2'd2;

  localparam logic [7:0]  IGNORED_CLASS     = 8'd2;
  localparam logic [4:0]  QUEUE_LIMIT_RESET = 5'd16;
  localparam logic [15:0] PACE_RESET        = 16'd1;
  localparam logic [31:0] PEER_RESET        = 32'd0;
  localparam int unsigned ID_W              = 16;
  localparam int unsigned STAMP_W           = 32;

  typedef struct packed {
    logic push;
    logic pop;
    logic to_high;
  } q_cmd_t;

  typedef struct packed {
    logic high_empty;
    logic low_empty;
    logic high_full;
    logic low_full;
  } q_stat_t;

endpackage

// ===== sv/pqb_ram.sv =====
// generic simple dual-port ram with registered read
module pqb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pqb_queues.sv =====
// head and fill pointers of both queues over one shared entry ram
module pqb_queues
  import pqb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_cmd_t             cmd_i,
  input  logic [4:0]         limit_i,
  input  logic [ID_W-1:0]    id_i,
  input  logic [STAMP_W-1:0] stamp_i,
  output q_stat_t            stat_o,
  output logic [4:0]         high_count_o,
  output logic [4:0]         low_count_o,
  output logic [ID_W-1:0]    rd_id_o,
  output logic [STAMP_W-1:0] rd_stamp_o
);

  localparam int unsigned AW      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW      = (CW > 5) ? CW : 5;
  localparam int unsigned RAM_D   = 2 << AW;
  localparam int unsigned ENTRY_W = ID_W + STAMP_W;
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);

  logic [AW-1:0] high_head_q, high_head_d, low_head_q, low_head_d;
  logic [CW-1:0] high_fill_q, high_fill_d, low_fill_q, low_fill_d;
  logic [AW-1:0] push_head, pop_head, slot, pop_next;
  logic [CW-1:0] push_fill;
  logic [CW:0]   slot_sum;
  logic [LW-1:0] lim, high_fill_x, low_fill_x;
  logic [ENTRY_W-1:0] rdata;

  assign lim         = (LW'(limit_i) > DEPTH_L) ? DEPTH_L : LW'(limit_i);
  assign high_fill_x = LW'(high_fill_q);
  assign low_fill_x  = LW'(low_fill_q);

  assign stat_o.high_empty = (high_fill_q == '0);
  assign stat_o.low_empty  = (low_fill_q == '0);
  assign stat_o.high_full  = (high_fill_x >= lim);
  assign stat_o.low_full   = (low_fill_x >= lim);
  assign high_count_o      = high_fill_x[4:0];
  assign low_count_o       = low_fill_x[4:0];

  assign push_head = cmd_i.to_high ? high_head_q : low_head_q;
  assign push_fill = cmd_i.to_high ? high_fill_q : low_fill_q;
  assign slot_sum  = (CW + 1)'(push_head) + (CW + 1)'(push_fill);
  assign slot      = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);
  assign pop_head  = cmd_i.to_high ? high_head_q : low_head_q;
  assign pop_next  = (pop_head == LAST) ? '0 : pop_head + 1'b1;

  always_comb begin
    high_head_d = high_head_q;
    low_head_d  = low_head_q;
    high_fill_d = high_fill_q;
    low_fill_d  = low_fill_q;
    if (cmd_i.push) begin
      if (cmd_i.to_high) begin
        high_fill_d = high_fill_q + 1'b1;
      end else begin
        low_fill_d = low_fill_q + 1'b1;
      end
    end else if (cmd_i.pop) begin
      if (cmd_i.to_high) begin
        high_fill_d = high_fill_q - 1'b1;
        high_head_d = pop_next;
      end else begin
        low_fill_d = low_fill_q - 1'b1;
        low_head_d = pop_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_head_q <= '0;
      low_head_q  <= '0;
      high_fill_q <= '0;
      low_fill_q  <= '0;
    end else begin
      high_head_q <= high_head_d;
      low_head_q  <= low_head_d;
      high_fill_q <= high_fill_d;
      low_fill_q  <= low_fill_d;
    end
  end

  pqb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_D)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i ({cmd_i.to_high, slot}),
    .wdata_i ({id_i, stamp_i}),
    .re_i    (cmd_i.pop),
    .raddr_i ({cmd_i.to_high, pop_head}),
    .rdata_o (rdata)
  );

  assign rd_id_o    = rdata[ENTRY_W-1 -: ID_W];
  assign rd_stamp_o = rdata[STAMP_W-1:0];

  a_high_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_fill_q <= CW'(QUEUE_DEPTH))
    else $error("high queue fill beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cmd_i.to_high ? high_fill_q != '0 : low_fill_q != '0))
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (cmd_i.to_high ? !stat_o.high_full : !stat_o.low_full))
    else $error("push into full queue");

endmodule

// ===== sv/paced_two_queue_priority_buffer.sv =====
// top level of the paced two-queue strict-priority packet buffer
// Usage:
//   Requests (arrival, tick, start or stop buffering) enter on the in_ channel
//   under valid/ready; each request gives exactly one result on the out_
//   channel, in order. Configuration is written through cfg_we_i, cfg_index_i
//   and cfg_data_i while no request is in flight.
// Pipeline: the request transfer issues the queue ram access and registers
//   the decision in the middle stage; the output register then takes the entry
//   read from the ram together with the wait and the queue counts.
// Throughput: one request per cycle while the output is not stalled; the decision path and the queue
//   pointers update at the transfer, so a pop may follow a push directly.
// Stall: the output register holds its result while out_ready_i is low; the
//   middle stage then fills and in_ready_o drops, so no result is lost.
// Reset: queues empty, not busy, not buffering, tick clock zero, queue limit
//   16, pace interval 1, peer address 0. The ram needs no clearing pass.
module paced_two_queue_priority_buffer
  import pqb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] packet_id_i,
  input  logic [31:0] prev_hop_i,
  input  logic [7:0]  traffic_class_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  action_o,
  output logic [15:0] out_packet_id_o,
  output logic [31:0] waited_ticks_o,
  output logic [4:0]  high_count_o,
  output logic [4:0]  low_count_o
);

  logic [4:0]  queue_limit_q;
  logic [15:0] pace_interval_q;
  logic [31:0] peer_address_q;

  logic        busy_q, busy_d, buffering_q, buffering_d;
  logic [15:0] pace_left_q, pace_left_d, pace_eff, pace_dec;
  logic [31:0] tick_q, tick_d;

  logic        s1_valid_q;
  action_e     s1_action_q, act;
  logic [15:0] s1_id_q;
  logic [31:0] s1_tick_q;

  logic        out_valid_q;
  action_e     out_action_q, out_action_d;
  logic [15:0] out_id_q, out_id_d;
  logic [31:0] out_wait_q, out_wait_d;
  logic [4:0]  out_high_q, out_low_q;

  logic        accept, advance, try_send;
  q_cmd_t      cmd, q_cmd;
  q_stat_t     stat;
  logic [4:0]  high_count, low_count;
  logic [15:0] rd_id;
  logic [31:0] rd_stamp;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign pace_eff   = (pace_interval_q == '0) ? 16'd1 : pace_interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_limit_q   <= QUEUE_LIMIT_RESET;
      pace_interval_q <= PACE_RESET;
      peer_address_q  <= PEER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_QUEUE_LIMIT:   queue_limit_q   <= cfg_data_i[4:0];
        CFG_PACE_INTERVAL: pace_interval_q <= cfg_data_i[15:0];
        CFG_PEER_ADDRESS:  peer_address_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_d      = busy_q;
    pace_left_d = pace_left_q;
    buffering_d = buffering_q;
    tick_d      = tick_q;
    cmd         = '0;
    act         = ACT_NONE;
    try_send    = 1'b0;
    pace_dec    = (pace_left_q != '0) ? pace_left_q - 1'b1 : '0;
    unique case (req_type_i)
      REQ_ARRIVAL: begin
        if (traffic_class_i == IGNORED_CLASS) begin
          act = ACT_IGNORE;
        end else if (!buffering_q && !busy_q) begin
          act         = ACT_PASS;
          busy_d      = 1'b1;
          pace_left_d = pace_eff;
        end else if (prev_hop_i == peer_address_q) begin
          cmd.to_high = 1'b1;
          cmd.push    = !stat.high_full;
          act         = stat.high_full ? ACT_DROP : ACT_QHIGH;
        end else begin
          cmd.push = !stat.low_full;
          act      = stat.low_full ? ACT_DROP : ACT_QLOW;
        end
      end
      REQ_TICK: begin
        if (tick_q != '1) begin
          tick_d = tick_q + 1'b1;
        end
        if (busy_q) begin
          pace_left_d = pace_dec;
          if (pace_dec == '0) begin
            busy_d   = 1'b0;
            try_send = 1'b1;
          end
        end
      end
      REQ_START: buffering_d = 1'b1;
      REQ_STOP: begin
        buffering_d = 1'b0;
        try_send    = !busy_q;
      end
    endcase
    if (try_send && (!stat.high_empty || !stat.low_empty)) begin
      act         = ACT_SENT;
      busy_d      = 1'b1;
      pace_left_d = pace_eff;
      cmd.pop     = 1'b1;
      cmd.to_high = !stat.high_empty;
    end
  end

  assign q_cmd = '{push: cmd.push && accept, pop: cmd.pop && accept, to_high: cmd.to_high};

  pqb_queues #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (q_cmd),
    .limit_i      (queue_limit_q),
    .id_i         (packet_id_i),
    .stamp_i      (tick_q),
    .stat_o       (stat),
    .high_count_o (high_count),
    .low_count_o  (low_count),
    .rd_id_o      (rd_id),
    .rd_stamp_o   (rd_stamp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pace_left_q <= '0;
      buffering_q <= 1'b0;
      tick_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_action_q <= ACT_NONE;
    end else begin
      if (accept) begin
        busy_q      <= busy_d;
        pace_left_q <= pace_left_d;
        buffering_q <= buffering_d;
        tick_q      <= tick_d;
        s1_action_q <= act;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_id_q   <= (req_type_i == REQ_ARRIVAL) ? packet_id_i : '0;
      s1_tick_q <= tick_d;
    end
  end

  always_comb begin
    out_action_d = s1_action_q;
    out_id_d     = s1_id_q;
    out_wait_d   = '0;
    if (s1_action_q == ACT_SENT) begin
      out_id_d   = rd_id;
      out_wait_d = (s1_tick_q >= rd_stamp) ? s1_tick_q - rd_stamp : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_action_q <= ACT_NONE;
    end else if (advance) begin
      out_valid_q  <= s1_valid_q;
      out_action_q <= out_action_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_id_q   <= out_id_d;
      out_wait_q <= out_wait_d;
      out_high_q <= high_count;
      out_low_q  <= low_count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_action_q;
  assign out_packet_id_o = out_id_q;
  assign waited_ticks_o  = out_wait_q;
  assign high_count_o    = out_high_q;
  assign low_count_o     = out_low_q;

  a_busy_paced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pace_left_q != '0)
    else $error("busy with no pacing ticks left");

  a_send_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_action_q == ACT_SENT) |-> busy_q)
    else $error("send without starting a pacing interval");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_action_q)))
    else $error("middle stage lost a stalled result");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the paced two-queue priority buffer
module tb;
  import pqb_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PER_PHASE   = 183;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    action_e     action;
    logic [15:0] id;
    logic [31:0] waited;
    logic [4:0]  high_count;
    logic [4:0]  low_count;
  } buffer_result_t;

  class paced_buffer_mirror;
    logic [15:0]    ids [2][DEPTH];
    logic [31:0]    stamps [2][DEPTH];
    int unsigned    head [2];
    int unsigned    fill [2];
    bit             busy;
    bit             buffering;
    int unsigned    pace_left;
    logic [31:0]    clock;
    logic [4:0]     limit;
    logic [15:0]    pace;
    logic [31:0]    peer;
    buffer_result_t pending [$];
    int unsigned    errors;
    int unsigned    requests;
    int unsigned    tally [7];

    function new();
      head      = '{0, 0};
      fill      = '{0, 0};
      busy      = 1'b0;
      buffering = 1'b0;
      pace_left = 0;
      clock     = '0;
      limit     = QUEUE_LIMIT_RESET;
      pace      = PACE_RESET;
      peer      = PEER_RESET;
      errors    = 0;
      requests  = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_QUEUE_LIMIT:   limit = data[4:0];
        CFG_PACE_INTERVAL: pace = data[15:0];
        CFG_PEER_ADDRESS:  peer = data;
        default: ;
      endcase
    endfunction

    function void start_pacing();
      busy      = 1'b1;
      pace_left = (pace == 16'd0) ? 1 : int'(pace);
    endfunction

    function bit enqueue(int q, logic [15:0] pid);
      int unsigned eff;
      int unsigned slot;
      eff = (limit > DEPTH) ? DEPTH : int'(limit);
      if (fill[q] >= eff) return 1'b0;
      slot = (head[q] + fill[q]) % DEPTH;
      ids[q][slot]    = pid;
      stamps[q][slot] = clock;
      fill[q]++;
      return 1'b1;
    endfunction

    function bit send_head(output logic [15:0] id, output logic [31:0] waited);
      int q;
      int unsigned slot;
      id     = '0;
      waited = '0;
      if (busy) return 1'b0;
      q = (fill[0] != 0) ? 0 : ((fill[1] != 0) ? 1 : -1);
      if (q < 0) return 1'b0;
      start_pacing();
      slot    = head[q];
      id      = ids[q][slot];
      waited  = (clock >= stamps[q][slot]) ? clock - stamps[q][slot] : '0;
      head[q] = (slot + 1) % DEPTH;
      fill[q]--;
      return 1'b1;
    endfunction

    function void take_request(logic [1:0] req, logic [15:0] pid, logic [31:0] hop,
                               logic [7:0] cls);
      buffer_result_t r;
      bit to_high;
      r.action = ACT_NONE;
      r.id     = '0;
      r.waited = '0;
      to_high  = (hop == peer);
      case (req)
        REQ_ARRIVAL: begin
          r.id = pid;
          if (cls == IGNORED_CLASS) begin
            r.action = ACT_IGNORE;
          end else if (!buffering && !busy) begin
            r.action = ACT_PASS;
            start_pacing();
          end else if (enqueue(to_high ? 0 : 1, pid)) begin
            r.action = to_high ? ACT_QHIGH : ACT_QLOW;
          end else begin
            r.action = ACT_DROP;
          end
        end
        REQ_TICK: begin
          if (clock != '1) clock++;
          if (busy) begin
            if (pace_left != 0) pace_left--;
            if (pace_left == 0) begin
              busy = 1'b0;
              if (send_head(r.id, r.waited)) r.action = ACT_SENT;
            end
          end
        end
        REQ_START: buffering = 1'b1;
        REQ_STOP: begin
          buffering = 1'b0;
          if (send_head(r.id, r.waited)) r.action = ACT_SENT;
        end
        default: ;
      endcase
      r.high_count = fill[0][4:0];
      r.low_count  = fill[1][4:0];
      tally[r.action]++;
      requests++;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(logic [2:0] action, logic [15:0] id, logic [31:0] waited,
                               logic [4:0] high_count, logic [4:0] low_count);
      buffer_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual action %0h id %0h",
                 $time, action, id);
        errors++;
      end else begin
        r = pending.pop_front();
        compare_field("action", 32'(r.action), 32'(action));
        compare_field("out_packet_id", 32'(r.id), 32'(id));
        compare_field("waited_ticks", r.waited, waited);
        compare_field("high_count", 32'(r.high_count), 32'(high_count));
        compare_field("low_count", 32'(r.low_count), 32'(low_count));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_index_i     = '0;
  logic [31:0] cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i      = '0;
  logic [15:0] packet_id_i     = '0;
  logic [31:0] prev_hop_i      = '0;
  logic [7:0]  traffic_class_i = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [2:0]  action_o;
  logic [15:0] out_packet_id_o;
  logic [31:0] waited_ticks_o;
  logic [4:0]  high_count_o;
  logic [4:0]  low_count_o;

  paced_buffer_mirror mirror;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;

  paced_two_queue_priority_buffer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .packet_id_i    (packet_id_i),
    .prev_hop_i     (prev_hop_i),
    .traffic_class_i(traffic_class_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .action_o       (action_o),
    .out_packet_id_o(out_packet_id_o),
    .waited_ticks_o (waited_ticks_o),
    .high_count_o   (high_count_o),
    .low_count_o    (low_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check each transfer, then choose the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      mirror.match_result(action_o, out_packet_id_o, waited_ticks_o, high_count_o,
                          low_count_o);
    end
    out_ready_i <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic push_request(logic [1:0] req, logic [15:0] pid, logic [31:0] hop,
                              logic [7:0] cls);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    packet_id_i     <= pid;
    prev_hop_i      <= hop;
    traffic_class_i <= cls;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mirror.take_request(req, pid, hop, cls);
  endtask

  task automatic random_request(int style);
    int unsigned pick;
    logic [1:0]  req;
    logic [31:0] hop;
    logic [7:0]  cls;
    pick = $urandom_range(0, 99);
    case (style)
      0: req = (pick < 45) ? REQ_ARRIVAL : (pick < 80) ? REQ_TICK :
               (pick < 90) ? REQ_START : REQ_STOP;
      1: req = (pick < 75) ? REQ_ARRIVAL : (pick < 85) ? REQ_TICK :
               (pick < 95) ? REQ_START : REQ_STOP;
      default: req = (pick < 15) ? REQ_ARRIVAL : (pick < 75) ? REQ_TICK :
                     (pick < 80) ? REQ_START : REQ_STOP;
    endcase
    hop = ($urandom_range(0, 1) == 0) ? mirror.peer : $urandom;
    cls = ($urandom_range(0, 7) == 0) ? IGNORED_CLASS : 8'($urandom_range(0, 255));
    push_request(req, 16'($urandom), hop, cls);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    mirror.write_reg(idx, data);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned count;
    int unsigned len;
    int          style;
    int unsigned saved_pct;
    logic [4:0]  lim;
    logic [15:0] pace;
    logic [31:0] peer;
    mirror = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: pass, queue behind pacing, paced send, idle ticks
    push_request(REQ_ARRIVAL, 16'h0001, 32'h0000_0001, 8'h00);
    push_request(REQ_ARRIVAL, 16'h0002, 32'h0000_0000, 8'h00);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    settle();
    write_reg(CFG_QUEUE_LIMIT, 32'hFFFF_FFE2);
    write_reg(CFG_PACE_INTERVAL, 32'hA5A5_0002);
    write_reg(CFG_PEER_ADDRESS, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;

    // buffering, full queues, ignored class, stop while busy or empty
    push_request(REQ_START, '0, '0, '0);
    push_request(REQ_START, '0, '0, '0);
    push_request(REQ_ARRIVAL, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    push_request(REQ_ARRIVAL, 16'h0000, 32'hFFFF_FFFF, 8'h00);
    push_request(REQ_ARRIVAL, 16'h1234, 32'hFFFF_FFFF, 8'h03);
    push_request(REQ_ARRIVAL, 16'h5555, 32'h0000_0000, 8'h01);
    push_request(REQ_ARRIVAL, 16'hAAAA, 32'h0000_0000, IGNORED_CLASS);
    push_request(REQ_ARRIVAL, 16'h0F0F, 32'h1234_5678, 8'h80);
    push_request(REQ_ARRIVAL, 16'hF0F0, 32'h0000_0000, 8'h7F);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_STOP, '0, '0, '0);
    push_request(REQ_STOP, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_START, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_STOP, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_TICK, '0, '0, '0);
    push_request(REQ_STOP, '0, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin lim = 5'd16; pace = 16'd1; peer = $urandom; end
        1: begin lim = 5'd0; pace = 16'd0; peer = 32'h0000_0000; end
        2: begin lim = 5'd31; pace = 16'd3; peer = 32'hFFFF_FFFF; end
        3: begin lim = 5'd1; pace = 16'd4; peer = $urandom; end
        4: begin lim = 5'd17; pace = 16'd2; peer = $urandom; end
        8: begin lim = 5'($urandom_range(1, 16)); pace = 16'hFFFF; peer = $urandom; end
        default: begin
          lim  = 5'($urandom_range(1, 16));
          pace = 16'($urandom_range(1, 6));
          peer = $urandom;
        end
      endcase
      write_reg(CFG_QUEUE_LIMIT, {27'($urandom), lim});
      write_reg(CFG_PACE_INTERVAL, {16'($urandom), pace});
      write_reg(CFG_PEER_ADDRESS, peer);
      cfg_we_i <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      count = 0;
      while (count < PER_PHASE) begin
        style     = $urandom_range(0, 2);
        len       = $urandom_range(12, 32);
        saved_pct = send_idle_pct;
        if ($urandom_range(0, 3) == 0) send_idle_pct = 0;
        for (int k = 0; k < len && count < PER_PHASE; k++) begin
          random_request(style);
          count++;
        end
        send_idle_pct = saved_pct;
      end
    end

    recv_stall_pct = 0;
    settle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d requests over %0d settings: %0d passes, %0d sends, %0d drops",
             mirror.requests, PHASES + 2, mirror.tally[ACT_PASS], mirror.tally[ACT_SENT],
             mirror.tally[ACT_DROP]);
    $display("queued %0d high and %0d low, %0d ignored, %0d with no action",
             mirror.tally[ACT_QHIGH], mirror.tally[ACT_QLOW], mirror.tally[ACT_IGNORE],
             mirror.tally[ACT_NONE]);
    if (mirror.errors == 0 && mirror.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
